/* hw/rtl/pab_pkg.sv */
// Shared codes and arithmetic helpers for the palette alpha blend block.
package pab_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic MODE_OVER = 1'b0;
  localparam logic MODE_ADD  = 1'b1;

  localparam logic [7:0] ALPHA_FULL = 8'd255;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  // floor(x / 255) for any 16-bit x up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  function automatic logic [7:0] over_channel(input logic [7:0] src, input logic [7:0] dst,
                                              input logic [7:0] a);
    logic [15:0] sum;
    sum = (16'(a) * 16'(src)) + (16'(ALPHA_FULL - a) * 16'(dst));
    return div255(sum);
  endfunction

  function automatic logic [7:0] add_channel(input logic [7:0] src, input logic [7:0] dst,
                                             input logic [7:0] a);
    logic [7:0] scaled;
    scaled = div255(16'(src) * 16'(a));
    return (dst == 8'd0) ? src : dst + scaled;
  endfunction

endpackage

/* hw/rtl/palette_alpha_blend_pixel.sv */
// Palette lookup and alpha blend, top level.
//
//  channel | signals                                   | transfers
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid/in_ready, command..dest_alpha    | palette write or one pixel
//  out     | out_valid/out_ready, out_red..changed     | one blended pixel
//  cfg     | cfg_write, cfg_data                       | blend_mode, no wait
//
// One transaction per clock in each direction while out_ready holds. A pixel is
// registered through the palette read into the middle stage, then blended into
// the output register. Palette writes produce no output and take effect for any
// pixel accepted in a later cycle. rst (synchronous) clears the valid flags and
// blend_mode; palette contents are undefined until written. A stalled output
// holds; the middle stage keeps accepting until it too is full.
module palette_alpha_blend_pixel
  import pab_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] color_index,
  input  logic [7:0] entry_red,
  input  logic [7:0] entry_green,
  input  logic [7:0] entry_blue,
  input  logic [7:0] entry_alpha,
  input  logic [7:0] dest_red,
  input  logic [7:0] dest_green,
  input  logic [7:0] dest_blue,
  input  logic [7:0] dest_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       changed
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  rgba_t palette [PALETTE_ENTRIES];

  logic       blend_mode;
  logic       in_accept;
  logic       in_range;
  logic       s1_advance;

  // Middle stage: palette read data plus the pixel's destination
  logic       s1_valid;
  logic       s1_transparent;
  rgba_t      s1_entry;
  rgba_t      s1_dest;

  rgba_t      blend_next;

  assign in_range   = {1'b0, color_index} < 9'(PALETTE_ENTRIES);
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign in_accept  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_OVER;
    end else if (cfg_write) begin
      blend_mode <= cfg_data;
    end
  end

  // Palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_accept && command == CMD_WRITE && in_range) begin
      palette[color_index[AW-1:0]] <= '{alpha: entry_alpha, blue: entry_blue,
                                        green: entry_green, red: entry_red};
    end
    if (in_accept && command == CMD_PIXEL) begin
      s1_entry <= palette[color_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid && command == CMD_PIXEL;
    end
    if (in_accept && command == CMD_PIXEL) begin
      s1_transparent <= !in_range || color_index == 8'd0;
      s1_dest        <= '{alpha: dest_alpha, blue: dest_blue,
                          green: dest_green, red: dest_red};
    end
  end

  always_comb begin
    blend_next = s1_dest;
    if (!s1_transparent) begin
      case (blend_mode)
        MODE_OVER: begin
          blend_next.red   = over_channel(s1_entry.red,   s1_dest.red,   s1_entry.alpha);
          blend_next.green = over_channel(s1_entry.green, s1_dest.green, s1_entry.alpha);
          blend_next.blue  = over_channel(s1_entry.blue,  s1_dest.blue,  s1_entry.alpha);
        end
        default: begin
          blend_next.red   = add_channel(s1_entry.red,   s1_dest.red,   s1_entry.alpha);
          blend_next.green = add_channel(s1_entry.green, s1_dest.green, s1_entry.alpha);
          blend_next.blue  = add_channel(s1_entry.blue,  s1_dest.blue,  s1_entry.alpha);
          // destination alpha accumulates, wrapping
          blend_next.alpha = s1_dest.alpha + s1_entry.alpha;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
    if (s1_advance && s1_valid) begin
      out_red   <= blend_next.red;
      out_green <= blend_next.green;
      out_blue  <= blend_next.blue;
      out_alpha <= blend_next.alpha;
      changed   <= !s1_transparent;
    end
  end

endmodule

/* hw/rtl/pab_checker.sv */
// Port-level assertions for the palette alpha blend block, with bind.
module pab_checker
  import pab_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha,
  input logic       changed
);

  // A pixel transaction fills the middle stage, after which the output register
  // is never empty: either that pixel has arrived or an older one is still stalled there
  a_pixel_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == CMD_PIXEL |=> ##1 out_valid)
    else $error("output empty two cycles after a pixel transaction");

  // Empty output means nothing can block the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(changed))
    else $error("output payload changed while stalled");

endmodule

bind palette_alpha_blend_pixel pab_checker u_pab_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .command   (command),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha),
  .changed   (changed)
);

/* tb/tb_palette_alpha_blend_pixel.sv */
// Self-checking testbench for the palette lookup and alpha blend block.
module tb_palette_alpha_blend_pixel;
  import pab_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The longest quiet stretch in a correct run is a receiver stall or a config
  // pause, so this is far above it.
  localparam int STALL_LIMIT = 5000;
  // Cycles to let the two-stage pipe settle once nothing is expected.
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       changed;
  } pixel_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_data = MODE_OVER;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = CMD_WRITE;
  logic [7:0] color_index = '0;
  logic [7:0] entry_red = '0;
  logic [7:0] entry_green = '0;
  logic [7:0] entry_blue = '0;
  logic [7:0] entry_alpha = '0;
  logic [7:0] dest_red = '0;
  logic [7:0] dest_green = '0;
  logic [7:0] dest_blue = '0;
  logic [7:0] dest_alpha = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       changed;

  palette_alpha_blend_pixel dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .color_index(color_index),
    .entry_red  (entry_red),
    .entry_green(entry_green),
    .entry_blue (entry_blue),
    .entry_alpha(entry_alpha),
    .dest_red   (dest_red),
    .dest_green (dest_green),
    .dest_blue  (dest_blue),
    .dest_alpha (dest_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .changed    (changed)
  );

  always #1 clk = ~clk;

  // Shadow of the block's state: palette contents and the blend mode.
  rgba_t         palette_shadow [256];
  bit            entry_loaded [256];
  logic [7:0]    loaded_indexes [$];
  logic          mode_shadow = MODE_OVER;

  // Blended pixels still owed by the block, oldest first.
  pixel_result_t blended_expect_q [$];

  int            in_idle_pct = 0;
  int            out_idle_pct = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  function automatic rgba_t rgba(input int r, input int g, input int b, input int a);
    rgba_t c;
    c.red   = 8'(r);
    c.green = 8'(g);
    c.blue  = 8'(b);
    c.alpha = 8'(a);
    return c;
  endfunction

  // Alpha-over: exact floor((a*src + (255-a)*dst) / 255); never exceeds 255.
  function automatic logic [7:0] over_blend(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] a);
    int unsigned weighted;
    weighted = int'(a) * int'(s) + (255 - int'(a)) * int'(d);
    return 8'(weighted / 255);
  endfunction

  // Additive: a zero destination channel takes the palette color outright,
  // anything else gains the alpha-scaled color and wraps modulo 256.
  function automatic logic [7:0] additive_blend(input logic [7:0] s, input logic [7:0] d,
                                                input logic [7:0] a);
    int unsigned scaled;
    if (d == 8'd0) return s;
    scaled = (int'(s) * int'(a)) / 255;
    return 8'(int'(d) + scaled);
  endfunction

  function automatic pixel_result_t blend_pixel(input logic [7:0] idx, input rgba_t dst);
    pixel_result_t r;
    rgba_t         src;
    // Index 0 is transparent: destination passes through untouched.
    if (idx == 8'd0) begin
      r = '{red: dst.red, green: dst.green, blue: dst.blue, alpha: dst.alpha,
            changed: 1'b0};
      return r;
    end
    src = palette_shadow[idx];
    if (mode_shadow == MODE_OVER) begin
      r.red   = over_blend(src.red,   dst.red,   src.alpha);
      r.green = over_blend(src.green, dst.green, src.alpha);
      r.blue  = over_blend(src.blue,  dst.blue,  src.alpha);
      r.alpha = dst.alpha;
    end else begin
      r.red   = additive_blend(src.red,   dst.red,   src.alpha);
      r.green = additive_blend(src.green, dst.green, src.alpha);
      r.blue  = additive_blend(src.blue,  dst.blue,  src.alpha);
      r.alpha = dst.alpha + src.alpha;
    end
    r.changed = 1'b1;
    return r;
  endfunction

  // Offers one input transaction, possibly after some idle cycles, and waits
  // for it to be taken. Valid is left high on return so back-to-back calls
  // never lower and raise it within the same time step.
  task automatic send_transaction(input logic cmd, input logic [7:0] idx,
                                  input rgba_t entry, input rgba_t dst);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    color_index <= idx;
    entry_red   <= entry.red;
    entry_green <= entry.green;
    entry_blue  <= entry.blue;
    entry_alpha <= entry.alpha;
    dest_red    <= dst.red;
    dest_green  <= dst.green;
    dest_blue   <= dst.blue;
    dest_alpha  <= dst.alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge: update the shadow state in acceptance order, so a
    // write is seen by every pixel accepted after it.
    if (cmd == CMD_WRITE) begin
      palette_shadow[idx] = entry;
      if (!entry_loaded[idx] && idx != 8'd0) loaded_indexes.push_back(idx);
      entry_loaded[idx] = 1'b1;
    end else begin
      blended_expect_q.push_back(blend_pixel(idx, dst));
    end
  endtask

  task automatic write_entry(input logic [7:0] idx, input rgba_t entry);
    send_transaction(CMD_WRITE, idx, entry, rgba($urandom, $urandom, $urandom, $urandom));
  endtask

  task automatic blend(input logic [7:0] idx, input rgba_t dst);
    send_transaction(CMD_PIXEL, idx, rgba($urandom, $urandom, $urandom, $urandom), dst);
  endtask

  // Drop valid and wait until every owed pixel is out, then let the pipe settle
  // in case a palette write is still passing through.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blended_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_blend_mode(input logic mode);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_write   <= 1'b0;
    mode_shadow  = mode;
  endtask

  // Mostly 0..255 at random, with the channel extremes weighted up so the
  // zero-destination branch of additive mode comes up often.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic rgba_t pick_pixel();
    return rgba(pick_channel(), pick_channel(), pick_channel(), pick_channel());
  endfunction

  // Pixels only ever name a loaded entry or the transparent index.
  function automatic logic [7:0] pick_loaded_index();
    if (loaded_indexes.size() == 0 || $urandom_range(0, 9) == 0) return 8'd0;
    return loaded_indexes[$urandom_range(0, loaded_indexes.size() - 1)];
  endfunction

  task automatic random_transaction();
    logic [7:0] idx;
    if (loaded_indexes.size() == 0 || $urandom_range(0, 99) < 25) begin
      idx = 8'($urandom);
      write_entry(idx, pick_pixel());
      // Now and then read the entry right behind its write.
      if (idx != 8'd0 && $urandom_range(0, 4) == 0) blend(idx, pick_pixel());
    end else begin
      blend(pick_loaded_index(), pick_pixel());
    end
  endtask

  // Extremes of alpha and destination in alpha-over mode, plus the
  // transparent index and a stored-but-never-read write to entry 0.
  task automatic test_directed_over();
    in_idle_pct  = 20;
    out_idle_pct = 68;
    set_blend_mode(MODE_OVER);
    write_entry(8'd1,   rgba(200, 100, 0, 0));
    write_entry(8'd2,   rgba(255, 0, 128, 255));
    write_entry(8'd255, rgba(255, 255, 255, 255));
    write_entry(8'd0,   rgba(17, 34, 51, 68));
    write_entry(8'd128, rgba(0, 255, 1, 128));
    write_entry(8'd3,   rgba(255, 255, 255, 1));
    blend(8'd0,   rgba(255, 255, 255, 255));
    blend(8'd0,   rgba(0, 0, 0, 0));
    blend(8'd1,   rgba(255, 255, 255, 255));
    blend(8'd2,   rgba(0, 0, 0, 0));
    blend(8'd255, rgba(0, 0, 0, 0));
    blend(8'd128, rgba(255, 0, 128, 254));
    blend(8'd3,   rgba(255, 0, 255, 255));
    drain_pipe();
  endtask

  // Additive mode: zero destination channels, wrap of color and alpha,
  // alpha of zero, transparency, and a write immediately followed by a read.
  task automatic test_directed_additive();
    set_blend_mode(MODE_ADD);
    blend(8'd2,   rgba(0, 0, 0, 0));
    blend(8'd255, rgba(255, 255, 255, 255));
    blend(8'd128, rgba(1, 0, 200, 200));
    blend(8'd1,   rgba(10, 0, 20, 30));
    blend(8'd0,   rgba(9, 8, 7, 6));
    write_entry(8'd4, rgba(128, 64, 32, 200));
    blend(8'd4,   rgba(200, 0, 100, 100));
    drain_pipe();
  endtask

  // Random traffic in two halves, flipping the blend mode at the midpoint.
  task automatic test_random_traffic(input int items, input int in_pct, input int out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (items / 2) random_transaction();
    drain_pipe();
    set_blend_mode(~mode_shadow);
    repeat (items - items / 2) random_transaction();
    drain_pipe();
  endtask

  // Output side: random backpressure and the result check. Both read values
  // from before the edge, so they see the transaction the block saw.
  always @(posedge clk) begin
    pixel_result_t want;
    pixel_result_t got;
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    if (!rst && out_valid && out_ready) begin
      got = '{red: out_red, green: out_green, blue: out_blue, alpha: out_alpha,
              changed: changed};
      if (blended_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected pixel: r=%0d g=%0d b=%0d a=%0d changed=%0b",
                   got.red, got.green, got.blue, got.alpha, got.changed);
      end else begin
        want = blended_expect_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.changed !== want.changed) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d changed=%0b, got r=%0d g=%0d b=%0d a=%0d changed=%0b",
                     want.red, want.green, want.blue, want.alpha, want.changed,
                     got.red, got.green, got.blue, got.alpha, got.changed);
        end
      end
    end
  end

  // Watchdog: give up if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_over();
    test_directed_additive();
    test_random_traffic(200, 20, 68);
    test_random_traffic(200, 68, 20);
    test_random_traffic(200, 0, 0);
    drain_pipe();
    if (mismatch_count == 0 && blended_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
